// ===== hdl/jpeg_huffman_bit_packer_defines.svh =====
// Assertion macros used by the checker file of the bit packer.
`ifndef JPEG_HUFFMAN_BIT_PACKER_DEFINES_SVH
`define JPEG_HUFFMAN_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JHBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JHBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/jhbp_pkg.sv =====
// Shared constants, request codes and queue entry type of the bit packer.
`default_nettype none
package jhbp_pkg;

	// Table store geometry.
	localparam int NUM_TABLES      = 4;
	localparam int MAX_CODE_LENGTH = 16;
	localparam int SYMS_PER_TABLE  = 256;
	localparam int STORE_DEPTH     = NUM_TABLES * SYMS_PER_TABLE;
	localparam int ADDR_W          = $clog2(STORE_DEPTH);

	// Field and store widths.
	localparam int CODE_W  = 16;
	localparam int LEN_W   = 5;
	localparam int ENTRY_W = LEN_W + CODE_W;
	localparam int RCODE_W = 17;
	localparam int ACC_W   = 23;
	localparam int TOT_W   = 5;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Byte stuffing.
	localparam logic [7:0] BYTE_FF    = 8'hFF;
	localparam logic [7:0] BYTE_STUFF = 8'h00;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_START    = 3'd0,
		REQ_DEFINE   = 3'd1,
		REQ_EMIT_SYM = 3'd2,
		REQ_EMIT_RAW = 3'd3,
		REQ_FLUSH    = 3'd4
	} req_type_t;

	// One command for the back end: append bits, or pad to a byte boundary.
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] value;
		logic [LEN_W-1:0]  count;
	} bits_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/jhbp_req_if.sv =====
// Request channel: valid/ready handshake carrying one input item.
`default_nettype none
interface jhbp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [1:0]  table_select;
	logic [7:0]  symbol;
	logic [4:0]  code_length;
	logic [15:0] raw_value;
	logic [4:0]  bit_count;

	modport source (
		output valid, req_type, table_select, symbol, code_length, raw_value, bit_count,
		input  ready
	);
	modport sink (
		input  valid, req_type, table_select, symbol, code_length, raw_value, bit_count,
		output ready
	);
endinterface
`default_nettype wire

// ===== hdl/jhbp_res_if.sv =====
// Result channel: valid/ready handshake carrying one output byte.
`default_nettype none
interface jhbp_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_stuffing;
	logic       last_of_run;

	modport source (
		output valid, out_byte, is_stuffing, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_byte, is_stuffing, last_of_run,
		output ready
	);
endinterface
`default_nettype wire

// ===== hdl/jhbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jhbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/jhbp_front.sv =====
// Front end: accepts items, builds the code tables and issues bit commands.
`default_nettype none
module jhbp_front import jhbp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jhbp_req_if.sink   req,
	output bits_cmd_t  push_cmd,
	output logic       push_valid,
	input  wire logic  push_ready
);

	typedef enum logic [1:0] {
		KIND_SYM   = 2'd0,
		KIND_RAW   = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	logic                clr_busy_q;
	logic [ADDR_W-1:0]   clr_idx_q;
	logic [RCODE_W-1:0]  rc_q;
	logic [LEN_W-1:0]    cur_len_q;

	logic                valid_s1;
	kind_t               kind_s1;
	logic [CODE_W-1:0]   value_s1;
	logic [LEN_W-1:0]    count_s1;

	logic                accept;
	logic                s1_done;
	logic                need_push;
	logic                tsel_ok;
	logic [ADDR_W-1:0]   addr;
	logic                len_ok;
	logic [LEN_W-1:0]    shift_amt;
	logic [RCODE_W-1:0]  shifted;
	logic [RCODE_W-1:0]  limit;
	logic                fits;
	logic                def_en;
	logic                def_write;
	logic [LEN_W-1:0]    raw_cnt;
	logic [CODE_W-1:0]   raw_masked;
	logic                load;
	kind_t               load_kind;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [ENTRY_W-1:0]  ram_rdata;
	logic [LEN_W-1:0]    sym_len;

	// Store address of a table entry.
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [1:0] tsel,
		input logic [7:0] sym);
		return ADDR_W'(int'(tsel) * SYMS_PER_TABLE + int'(sym));
	endfunction

	// Handshake: a held stage-one item must drain first; no transfers while clearing.
	assign need_push = valid_s1 && (kind_s1 == KIND_FLUSH ||
		(kind_s1 == KIND_SYM ? sym_len != '0 : count_s1 != '0));
	assign s1_done   = !need_push || push_ready;
	assign req.ready = !clr_busy_q && s1_done;
	assign accept    = req.valid && req.ready;

	assign tsel_ok = int'(req.table_select) < NUM_TABLES;
	assign addr    = entry_addr(req.table_select, req.symbol);

	// Canonical code construction for a define item.
	assign len_ok = tsel_ok && req.code_length != '0 && req.code_length <= LEN_W'(16) &&
		req.code_length <= LEN_W'(MAX_CODE_LENGTH) && req.code_length >= cur_len_q;
	assign shift_amt = req.code_length - cur_len_q;
	assign shifted   = rc_q << shift_amt;
	assign limit     = RCODE_W'(1) << req.code_length;
	assign fits      = shifted < limit;
	assign def_en    = accept && req.req_type == REQ_DEFINE && len_ok;
	assign def_write = def_en && fits;

	// Clearing pass after reset, then define writes.
	assign ram_we    = clr_busy_q || def_write;
	assign ram_waddr = clr_busy_q ? clr_idx_q : addr;
	assign ram_wdata = clr_busy_q ? '0 : {req.code_length, shifted[CODE_W-1:0]};
	assign ram_re    = accept && req.req_type == REQ_EMIT_SYM && tsel_ok;

	jhbp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// Raw bit count saturates at 16 and the value is masked to it.
	assign raw_cnt    = req.bit_count > LEN_W'(16) ? LEN_W'(16) : req.bit_count;
	assign raw_masked = req.raw_value & CODE_W'((RCODE_W'(1) << raw_cnt) - RCODE_W'(1));

	// Classify the accepted item for stage one.
	always_comb begin
		load      = 1'b0;
		load_kind = KIND_RAW;
		case (req.req_type)
			REQ_EMIT_SYM: begin
				load      = tsel_ok;
				load_kind = KIND_SYM;
			end
			REQ_EMIT_RAW: begin
				load      = raw_cnt != '0;
				load_kind = KIND_RAW;
			end
			REQ_FLUSH: begin
				load      = 1'b1;
				load_kind = KIND_FLUSH;
			end
			default: begin
				load      = 1'b0;
				load_kind = KIND_RAW;
			end
		endcase
	end

	// Clearing pass sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Running code and current length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q      <= '0;
			cur_len_q <= LEN_W'(1);
		end else if (accept && req.req_type == REQ_START) begin
			rc_q      <= '0;
			cur_len_q <= LEN_W'(1);
		end else if (def_en) begin
			cur_len_q <= req.code_length;
			rc_q      <= fits ? shifted + 1'b1 : shifted;
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= load;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept && load) begin
			kind_s1  <= load_kind;
			value_s1 <= raw_masked;
			count_s1 <= raw_cnt;
		end
	end

	// Table lookup result; lengths above 16 are clipped.
	assign sym_len = ram_rdata[ENTRY_W-1:CODE_W] > LEN_W'(16) ? LEN_W'(16) :
		ram_rdata[ENTRY_W-1:CODE_W];

	// Command toward the queue.
	assign push_valid     = need_push;
	assign push_cmd.flush = kind_s1 == KIND_FLUSH;
	assign push_cmd.value = kind_s1 == KIND_SYM ? ram_rdata[CODE_W-1:0] : value_s1;
	assign push_cmd.count = kind_s1 == KIND_SYM ? sym_len :
		(kind_s1 == KIND_FLUSH ? '0 : count_s1);

endmodule
`default_nettype wire

// ===== hdl/jhbp_queue.sv =====
// Small FIFO of bit commands between the front and back ends.
`default_nettype none
module jhbp_queue import jhbp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bits_cmd_t push_cmd,
	input  wire logic      push_valid,
	output logic           push_ready,
	output bits_cmd_t      pop_cmd,
	output logic           pop_valid,
	input  wire logic      pop_ready
);

	bits_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/jhbp_back.sv =====
// Back end: bit accumulator, byte output and 0xFF stuffing.
`default_nettype none
module jhbp_back import jhbp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bits_cmd_t pop_cmd,
	input  wire logic      pop_valid,
	output logic           pop_ready,
	jhbp_res_if.source     res
);

	logic [ACC_W-1:0]  acc_q;
	logic [TOT_W-1:0]  tot_q;
	logic              stuff_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_stuff_q;
	logic              out_last_q;

	logic              step;
	logic              have_byte;
	logic [ACC_W-1:0]  acc_shr;
	logic [7:0]        next_byte;
	logic [TOT_W-1:0]  tot_after;
	logic [6:0]        pend;
	logic [3:0]        pad;
	logic [LEN_W-1:0]  ld_cnt;
	logic [CODE_W-1:0] ld_val;
	logic              do_load;

	// The output register advances when empty or when its byte is taken.
	assign step      = !out_valid_q || res.ready;
	assign have_byte = tot_q >= TOT_W'(8);
	assign tot_after = tot_q - TOT_W'(8);
	assign acc_shr   = acc_q >> tot_after;
	assign next_byte = acc_shr[7:0];

	// A new command is taken once fewer than 8 bits remain and no stuffing is owed.
	assign pop_ready = !stuff_q && !have_byte;
	assign do_load   = pop_valid && pop_ready;

	// Pending bits, padding length and the bits to append.
	assign pend   = acc_q[6:0] & 7'((8'(1) << tot_q[2:0]) - 8'(1));
	assign pad    = tot_q[2:0] == 3'd0 ? 4'd0 : 4'd8 - {1'b0, tot_q[2:0]};
	assign ld_cnt = pop_cmd.flush ? LEN_W'(pad) : pop_cmd.count;
	assign ld_val = pop_cmd.flush ? CODE_W'((8'(1) << pad) - 8'(1)) : pop_cmd.value;

	// Accumulator and stuffing flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			tot_q   <= '0;
			stuff_q <= 1'b0;
		end else if (stuff_q) begin
			if (step) begin
				stuff_q <= 1'b0;
			end
		end else if (have_byte) begin
			if (step) begin
				tot_q   <= tot_after;
				stuff_q <= next_byte == BYTE_FF;
			end
		end else if (do_load) begin
			acc_q <= (ACC_W'(pend) << ld_cnt) | ACC_W'(ld_val);
			tot_q <= tot_q + ld_cnt;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= stuff_q || have_byte;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (step) begin
			if (stuff_q) begin
				out_byte_q  <= BYTE_STUFF;
				out_stuff_q <= 1'b1;
				out_last_q  <= tot_q < TOT_W'(8);
			end else begin
				out_byte_q  <= next_byte;
				out_stuff_q <= 1'b0;
				out_last_q  <= next_byte != BYTE_FF && tot_after < TOT_W'(8);
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_byte    = out_byte_q;
	assign res.is_stuffing = out_stuff_q;
	assign res.last_of_run = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/jpeg_huffman_bit_packer.sv =====
// JPEG Huffman bit packer top level: front end, command queue and back end.
// Channels: req takes one item per transfer (valid and ready high at a clock
// edge): start a table build, define a symbol, emit a symbol code, emit raw
// bits or flush. res gives one byte of the coded stream per transfer, with a
// flag on stuffed 0x00 bytes and a flag on the last byte caused by an item.
// After reset the table store (1024 entries) is cleared one entry per cycle;
// req.ready stays low until that clearing pass ends, and every entry reads as
// length zero afterwards. Accumulator, running code and length return to reset
// values. Path: with the queue empty, the first byte of an item goes through
// the queue write, the accumulator load and the output register on its way to
// res; the table read happens at the transfer itself. Throughput: the front
// takes one item per cycle while neither the clearing pass nor a held stage-one
// item blocks it; the back end takes a command only once fewer than 8 bits
// remain and no stuffing is owed, and sends every whole byte before it takes the next.
// Start, define and silent items are taken by the front and reach no byte output.
// When res stalls, the output register holds its byte, the back end stops, the
// four-entry queue fills and req.ready then drops; nothing is lost.
`default_nettype none
module jpeg_huffman_bit_packer import jhbp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jhbp_req_if.sink   req,
	jhbp_res_if.source res
);

	bits_cmd_t push_cmd;
	logic      push_valid;
	logic      push_ready;
	bits_cmd_t pop_cmd;
	logic      pop_valid;
	logic      pop_ready;

	// Table build and lookup.
	jhbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Decoupling queue.
	jhbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_cmd    (pop_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Bit packing and byte output.
	jhbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_cmd   (pop_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.res       (res)
	);

endmodule
`default_nettype wire

// ===== hdl/jhbp_checker.sv =====
// Port-level checks on the result channel of the bit packer, bound to the top level.
`default_nettype none
`include "jpeg_huffman_bit_packer_defines.svh"
module jhbp_checker import jhbp_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] res_out_byte,
	input wire logic       res_is_stuffing,
	input wire logic       res_last_of_run
);

	// A stalled byte stays on the port.
	`JHBP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_out_byte), "res byte changed while stalled")

	// A stuffed byte is always zero.
	`JHBP_ASSERT_IMP(a_stuff_zero, clk, arst_n, res_valid && res_is_stuffing, res_out_byte == BYTE_STUFF, "stuffed byte is not zero")

	// A data byte of 0xFF is never the last byte of an item.
	`JHBP_ASSERT_IMP(a_ff_not_last, clk, arst_n, res_valid && !res_is_stuffing && res_out_byte == BYTE_FF, !res_last_of_run, "0xFF marked as last byte")

	// The stuffed byte follows a transferred 0xFF in the next cycle.
	`JHBP_ASSERT_NEXT(a_ff_then_stuff, clk, arst_n, res_valid && res_ready && !res_is_stuffing && res_out_byte == BYTE_FF, res_valid && res_is_stuffing, "missing stuffed byte after 0xFF")

endmodule

bind jpeg_huffman_bit_packer jhbp_checker u_jhbp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_out_byte    (res.out_byte),
	.res_is_stuffing (res.is_stuffing),
	.res_last_of_run (res.last_of_run)
);
`default_nettype wire
